// File: src/bcs_pkg.sv
// Shared constants, types and codes for the Bezier curve sampler.
package bcs_pkg;

	// Field widths fixed by the item formats.
	localparam int KIND_W  = 8;
	localparam int SLOT_W  = 10;
	localparam int POINT_W = 4;
	localparam int COORD_W = 20;

	// Internal accumulators are Q32 values; 48 bits hold every reachable value.
	localparam int ACC_W = 48;

	localparam int MAX_FRAMES   = 1024;
	localparam int SEGMENT_SIZE = 10 * 2 - 1;
	localparam int SAMPLE_COUNT = (SEGMENT_SIZE - 1) / 2;
	localparam logic [POINT_W-1:0] LAST_POINT = POINT_W'(SAMPLE_COUNT - 1);

	// Curve type codes on the input side.
	localparam logic [KIND_W-1:0] TYPE_STEPPED = 8'd1;
	localparam logic [KIND_W-1:0] TYPE_BEZIER  = 8'd2;

	// Entry kind codes on the result side.
	localparam logic ENTRY_STEPPED = 1'b0;
	localparam logic ENTRY_POINT   = 1'b1;

	// Q0.32 constants, rounded to nearest: 0.03, 0.006, 0.3 and 1/6.
	localparam logic signed [27:0] K_003   = 28'sd128849019;
	localparam logic signed [25:0] K_0006  = 26'sd25769804;
	localparam logic signed [31:0] K_03    = 32'sd1288490189;
	localparam logic signed [30:0] K_SIXTH = 31'sd715827883;

	// Load strobes of the setup stages.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	// Forward differencing start values of one axis.
	typedef struct packed {
		logic signed [ACC_W-1:0] d;
		logic signed [ACC_W-1:0] dd;
		logic signed [ACC_W-1:0] ddd;
	} axis_coef_t;

	// Item data that rides along the setup stages.
	typedef struct packed {
		logic              stepped;
		logic [SLOT_W-1:0] slot;
	} item_meta_t;

endpackage

// File: src/bcs_in_if.sv
// Input channel of the Bezier curve sampler: curve type, slot and control points.
interface bcs_in_if;
	logic                                   valid;
	logic                                   ready;
	logic        [bcs_pkg::KIND_W-1:0]      curve_type;
	logic        [bcs_pkg::SLOT_W-1:0]      frame_index;
	logic signed [bcs_pkg::COORD_W-1:0]     ctrl_x1;
	logic signed [bcs_pkg::COORD_W-1:0]     ctrl_y1;
	logic signed [bcs_pkg::COORD_W-1:0]     ctrl_x2;
	logic signed [bcs_pkg::COORD_W-1:0]     ctrl_y2;

	modport source (
		output valid, curve_type, frame_index, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2,
		input  ready
	);
	modport sink (
		input  valid, curve_type, frame_index, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2,
		output ready
	);
endinterface

// File: src/bcs_out_if.sv
// Result channel of the Bezier curve sampler: one marker or one sample point.
interface bcs_out_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   entry_kind;
	logic        [bcs_pkg::SLOT_W-1:0]      slot_index;
	logic        [bcs_pkg::POINT_W-1:0]     point_number;
	logic signed [bcs_pkg::COORD_W-1:0]     x_value;
	logic signed [bcs_pkg::COORD_W-1:0]     y_value;
	logic                                   last;

	modport source (
		output valid, entry_kind, slot_index, point_number, x_value, y_value, last,
		input  ready
	);
	modport sink (
		input  valid, entry_kind, slot_index, point_number, x_value, y_value, last,
		output ready
	);
endinterface

// File: src/bcs_axis_setup.sv
// Setup datapath of one axis: scaled sums and products giving d, dd and ddd.
module bcs_axis_setup (
	input  logic                              clk,
	input  bcs_pkg::stage_en_t                en,
	input  logic signed [bcs_pkg::COORD_W-1:0] c1_s1,
	input  logic signed [bcs_pkg::COORD_W-1:0] c2_s1,
	output bcs_pkg::axis_coef_t               coef
);
	import bcs_pkg::*;

	// Stage 2: the operands of the three products.
	logic signed [21:0] tdiff_s2;
	logic signed [22:0] hsum_s2;
	logic signed [19:0] c1_s2;
	// Stage 3: raw products.
	logic signed [49:0] tprod_s3;
	logic signed [48:0] hprod_s3;
	logic signed [51:0] aprod_s3;
	// Stage 4: products rounded to Q32.
	logic signed [33:0] tmp_s4;
	logic signed [31:0] third_s4;
	logic signed [35:0] a03_s4;
	// Stage 5: third times one sixth.
	logic signed [62:0] sprod_s5;
	logic signed [33:0] tmp_s5;
	logic signed [31:0] third_s5;
	logic signed [35:0] a03_s5;
	// Stage 6: start values.
	logic signed [ACC_W-1:0] d_s6;
	logic signed [ACC_W-1:0] dd_s6;
	logic signed [ACC_W-1:0] ddd_s6;

	logic signed [21:0] tdiff_w;
	logic signed [22:0] hsum_w;
	logic signed [22:0] xdiff_w;
	logic signed [49:0] trnd_w;
	logic signed [48:0] hrnd_w;
	logic signed [51:0] arnd_w;
	logic signed [62:0] srnd_w;
	logic signed [30:0] sixth_w;

	// c2 - 2*c1 and 3*(c1 - c2) + 1.0 in Q16.
	assign tdiff_w = 22'(c2_s1) - (22'(c1_s1) <<< 1);
	assign xdiff_w = 23'(c1_s1) - 23'(c2_s1);
	assign hsum_w  = (xdiff_w <<< 1) + xdiff_w + 23'sd65536;

	// Round half up before dropping fraction bits.
	assign trnd_w  = tprod_s3 + (50'sd1 <<< 15);
	assign hrnd_w  = hprod_s3 + (49'sd1 <<< 15);
	assign arnd_w  = aprod_s3 + (52'sd1 <<< 15);
	assign srnd_w  = sprod_s5 + (63'sd1 <<< 31);
	assign sixth_w = srnd_w[62:32];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			tdiff_s2 <= tdiff_w;
			hsum_s2  <= hsum_w;
			c1_s2    <= c1_s1;
		end
		if (en.s3) begin
			tprod_s3 <= tdiff_s2 * K_003;
			hprod_s3 <= hsum_s2 * K_0006;
			aprod_s3 <= c1_s2 * K_03;
		end
		if (en.s4) begin
			tmp_s4   <= trnd_w[49:16];
			third_s4 <= hrnd_w[47:16];
			a03_s4   <= arnd_w[51:16];
		end
		if (en.s5) begin
			sprod_s5 <= third_s4 * K_SIXTH;
			tmp_s5   <= tmp_s4;
			third_s5 <= third_s4;
			a03_s5   <= a03_s4;
		end
		if (en.s6) begin
			d_s6   <= ACC_W'(a03_s5) + ACC_W'(tmp_s5) + ACC_W'(sixth_w);
			dd_s6  <= (ACC_W'(tmp_s5) <<< 1) + ACC_W'(third_s5);
			ddd_s6 <= ACC_W'(third_s5);
		end
	end

	assign coef.d   = d_s6;
	assign coef.dd  = dd_s6;
	assign coef.ddd = ddd_s6;

endmodule

// File: src/bcs_stepper.sv
// Forward differencing stepper that holds and emits the result transactions.
module bcs_stepper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bcs_pkg::item_meta_t meta,
	input  bcs_pkg::axis_coef_t coef_x,
	input  bcs_pkg::axis_coef_t coef_y,
	output logic                take,
	bcs_out_if.source           result
);
	import bcs_pkg::*;

	logic                    busy_q;
	logic                    stepped_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [POINT_W-1:0]      cnt_q;
	logic signed [ACC_W-1:0] px_q, dx_q, ddx_q, dddx_q;
	logic signed [ACC_W-1:0] py_q, dy_q, ddy_q, dddy_q;
	logic                    last_w;

	// Round a Q32 value to Q16 and clamp it to the output range.
	function automatic logic signed [COORD_W-1:0] to_q16(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		logic signed [31:0]      q;
		r = v + (ACC_W'(1) <<< 15);
		q = r[47:16];
		if (q > 32'sd524287) begin
			return 20'sd524287;
		end else if (q < -32'sd524288) begin
			return -20'sd524288;
		end else begin
			return q[COORD_W-1:0];
		end
	endfunction

	assign last_w = stepped_q || (cnt_q == LAST_POINT);
	assign take   = !busy_q || (result.ready && last_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && take) begin
			stepped_q <= meta.stepped;
			slot_q    <= meta.slot;
			cnt_q     <= '0;
			px_q      <= coef_x.d;
			dx_q      <= coef_x.d;
			ddx_q     <= coef_x.dd;
			dddx_q    <= coef_x.ddd;
			py_q      <= coef_y.d;
			dy_q      <= coef_y.d;
			ddy_q     <= coef_y.dd;
			dddy_q    <= coef_y.ddd;
		end else if (busy_q && result.ready) begin
			cnt_q <= cnt_q + POINT_W'(1);
			px_q  <= px_q + dx_q + ddx_q;
			dx_q  <= dx_q + ddx_q;
			ddx_q <= ddx_q + dddx_q;
			py_q  <= py_q + dy_q + ddy_q;
			dy_q  <= dy_q + ddy_q;
			ddy_q <= ddy_q + dddy_q;
		end
	end

	assign result.valid        = busy_q;
	assign result.entry_kind   = stepped_q ? ENTRY_STEPPED : ENTRY_POINT;
	assign result.slot_index   = slot_q;
	assign result.point_number = stepped_q ? '0 : cnt_q;
	assign result.x_value      = stepped_q ? '0 : to_q16(px_q);
	assign result.y_value      = stepped_q ? '0 : to_q16(py_q);
	assign result.last         = last_w;

endmodule

// File: src/bezier_curve_sampler_core.sv
// The first result follows its item through the input register, setup stages 2 to 6
// and the stepper, which emits a Bezier item's points one per cycle while the result
// side is ready; a stepped item gives one marker, and other items are dropped at stage 1.
// The six setup stages keep taking items while the stepper still emits points, until all six are full.
// Reset (arst_n low) clears all valid flags at once; data registers are not reset.
// Top level of the Bezier curve sampler.
module bezier_curve_sampler_core (
	input  logic      clk,
	input  logic      arst_n,
	bcs_in_if.sink    item,
	bcs_out_if.source result
);
	import bcs_pkg::*;

	// The setup runs as a chain of six stages. Stage 1 is the input register;
	// stages 2 to 6 live in the axis datapaths. Each stage moves forward when
	// the next one is empty or moving itself, so the chain drains as a queue
	// in front of the stepper.

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	item_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic signed [COORD_W-1:0] x1_s1, y1_s1, x2_s1, y2_s1;

	stage_en_t  en;
	logic       rdy2, rdy3, rdy4, rdy5, rdy6;
	logic       take;
	logic       load;
	logic       in_fire;
	logic       keep;
	axis_coef_t coef_x, coef_y;

	// Stepper side of the chain.
	assign load = valid_s6;
	assign rdy6 = !valid_s6 || take;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;

	assign en.s2 = valid_s1 && rdy2;
	assign en.s3 = valid_s2 && rdy3;
	assign en.s4 = valid_s3 && rdy4;
	assign en.s5 = valid_s4 && rdy5;
	assign en.s6 = valid_s5 && rdy6;

	assign item.ready = !valid_s1 || rdy2;
	assign in_fire    = item.valid && item.ready;

	// Only stepped and Bezier transactions for an existing slot carry on;
	// any other transaction is taken and dropped here without a result.
	assign keep = (32'(item.frame_index) < MAX_FRAMES) &&
		((item.curve_type == TYPE_STEPPED) || (item.curve_type == TYPE_BEZIER));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= keep;
			end else if (en.s2) begin
				valid_s1 <= 1'b0;
			end
			if (en.s2) begin
				valid_s2 <= 1'b1;
			end else if (en.s3) begin
				valid_s2 <= 1'b0;
			end
			if (en.s3) begin
				valid_s3 <= 1'b1;
			end else if (en.s4) begin
				valid_s3 <= 1'b0;
			end
			if (en.s4) begin
				valid_s4 <= 1'b1;
			end else if (en.s5) begin
				valid_s4 <= 1'b0;
			end
			if (en.s5) begin
				valid_s5 <= 1'b1;
			end else if (en.s6) begin
				valid_s5 <= 1'b0;
			end
			if (en.s6) begin
				valid_s6 <= 1'b1;
			end else if (load && take) begin
				valid_s6 <= 1'b0;
			end
		end
	end

	// Item data follows its stage; the core holds the control points only in stage 1.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meta_s1.stepped <= (item.curve_type == TYPE_STEPPED);
			meta_s1.slot    <= item.frame_index;
			x1_s1           <= item.ctrl_x1;
			y1_s1           <= item.ctrl_y1;
			x2_s1           <= item.ctrl_x2;
			y2_s1           <= item.ctrl_y2;
		end
		if (en.s2) begin
			meta_s2 <= meta_s1;
		end
		if (en.s3) begin
			meta_s3 <= meta_s2;
		end
		if (en.s4) begin
			meta_s4 <= meta_s3;
		end
		if (en.s5) begin
			meta_s5 <= meta_s4;
		end
		if (en.s6) begin
			meta_s6 <= meta_s5;
		end
	end

	// The two axes share nothing but the clock and the stage strobes.
	bcs_axis_setup u_axis_x (
		.clk   (clk),
		.en    (en),
		.c1_s1 (x1_s1),
		.c2_s1 (x2_s1),
		.coef  (coef_x)
	);

	bcs_axis_setup u_axis_y (
		.clk   (clk),
		.en    (en),
		.c1_s1 (y1_s1),
		.c2_s1 (y2_s1),
		.coef  (coef_y)
	);

	// The stepper holds the current result transaction and takes the next
	// set of start values in the same cycle as its last result leaves.
	bcs_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.meta   (meta_s6),
		.coef_x (coef_x),
		.coef_y (coef_y),
		.take   (take),
		.result (result)
	);

endmodule

// File: src/bcs_checker.sv
// Port-level checks of the Bezier curve sampler and their bind to the top level.
module bcs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               entry_kind,
	input logic        [bcs_pkg::SLOT_W-1:0]  slot_index,
	input logic        [bcs_pkg::POINT_W-1:0] point_number,
	input logic signed [bcs_pkg::COORD_W-1:0] x_value,
	input logic signed [bcs_pkg::COORD_W-1:0] y_value,
	input logic                               last
);
	import bcs_pkg::*;

	// A stalled result transaction keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(entry_kind) &&
			$stable(slot_index) && $stable(point_number) && $stable(x_value) &&
			$stable(y_value) && $stable(last))
		else $error("stalled result changed");

	// A stepped marker is a single, empty transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_kind == ENTRY_STEPPED) |->
			last && (point_number == '0) && (x_value == '0) && (y_value == '0))
		else $error("malformed stepped marker");

	// A Bezier point closes its curve exactly at the final sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_kind == ENTRY_POINT) |-> (last == (point_number == LAST_POINT)))
		else $error("last flag out of place");

	// Points of one curve follow each other with rising numbers and the same slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (entry_kind == ENTRY_POINT) && !last |=>
			out_valid && (entry_kind == ENTRY_POINT) &&
			(point_number == $past(point_number) + POINT_W'(1)) && $stable(slot_index))
		else $error("curve points out of sequence");

endmodule

bind bezier_curve_sampler_core bcs_checker u_bcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.entry_kind   (result.entry_kind),
	.slot_index   (result.slot_index),
	.point_number (result.point_number),
	.x_value      (result.x_value),
	.y_value      (result.y_value),
	.last         (result.last)
);

// File: verif/bcs_checker.sv
// Scoreboard of the Bezier curve sampler: predicts every result and compares each one.
module bcs_scoreboard (
	input  logic clk,
	input  logic arst_n,
	bcs_in_if    item,
	bcs_out_if   result,
	output int   faults,
	output int   waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	import bcs_pkg::*;

	// Q0.32 multipliers for 0.03, 0.006, 0.3 and 1/6, rounded to nearest.
	localparam longint MUL_003   = 64'sd128849019;
	localparam longint MUL_0006  = 64'sd25769804;
	localparam longint MUL_03    = 64'sd1288490189;
	localparam longint MUL_SIXTH = 64'sd715827883;
	localparam longint Q16_UNIT  = 64'sd65536;
	localparam longint SAT_HI    = 64'sd524287;
	localparam longint SAT_LO    = -64'sd524288;

	typedef struct packed {
		logic               kind;
		logic [SLOT_W-1:0]  slot;
		logic [POINT_W-1:0] point;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               last;
	} curve_entry_t;

	curve_entry_t due_points[$];
	curve_entry_t got;
	curve_entry_t want;
	int           fault_total = 0;

	// Arithmetic shift right by s with round half toward plus infinity.
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Rounds a Q32 value to Q16 and clamps it to the 20-bit output range.
	function automatic logic [COORD_W-1:0] q16_sat(input longint q32);
		longint r;
		r = round_shift(q32, 16);
		if (r > SAT_HI)
			r = SAT_HI;
		else if (r < SAT_LO)
			r = SAT_LO;
		return r[COORD_W-1:0];
	endfunction

	// Start values of one axis for forward differencing at a step of 0.1.
	function automatic void axis_start(input longint c1, input longint c2,
			output longint p, output longint d, output longint dd, output longint ddd);
		longint tmp;
		tmp = round_shift((c2 - 2 * c1) * MUL_003, 16);
		ddd = round_shift((3 * (c1 - c2) + Q16_UNIT) * MUL_0006, 16);
		dd  = 2 * tmp + ddd;
		d   = round_shift(c1 * MUL_03, 16) + tmp + round_shift(ddd * MUL_SIXTH, 32);
		p   = d;
	endfunction

	// Queues the results that one input transaction must produce.
	function automatic void predict_curve(input logic [KIND_W-1:0] kind,
			input logic [SLOT_W-1:0] slot,
			input logic signed [COORD_W-1:0] x1, input logic signed [COORD_W-1:0] y1,
			input logic signed [COORD_W-1:0] x2, input logic signed [COORD_W-1:0] y2);
		curve_entry_t e;
		longint px, dx, ddx, dddx, py, dy, ddy, dddy;
		if (int'(slot) >= MAX_FRAMES)
			return;
		if (kind == TYPE_STEPPED) begin
			e = '0;
			e.kind = ENTRY_STEPPED;
			e.slot = slot;
			e.last = 1'b1;
			due_points.push_back(e);
			return;
		end
		if (kind != TYPE_BEZIER)
			return;
		axis_start(longint'(x1), longint'(x2), px, dx, ddx, dddx);
		axis_start(longint'(y1), longint'(y2), py, dy, ddy, dddy);
		for (int k = 0; k < SAMPLE_COUNT; k++) begin
			e.kind  = ENTRY_POINT;
			e.slot  = slot;
			e.point = POINT_W'(k);
			e.x     = q16_sat(px);
			e.y     = q16_sat(py);
			e.last  = (e.point == LAST_POINT);
			due_points.push_back(e);
			dx  += ddx;
			dy  += ddy;
			ddx += dddx;
			ddy += dddy;
			px  += dx;
			py  += dy;
		end
	endfunction

	// Prints one line per fault and counts every fault.
	task automatic log_fault(input string msg);
		fault_total++;
		$display("bcs_scoreboard: %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting <= 0;
			faults  <= 0;
		end else begin
			// Results come first: an item accepted on this edge cannot have output yet.
			if (result.valid && result.ready) begin
				got = {result.entry_kind, result.slot_index, result.point_number,
					result.x_value, result.y_value, result.last};
				if (due_points.size() == 0) begin
					log_fault($sformatf("unexpected result, slot %0d point %0d",
						got.slot, got.point));
				end else begin
					want = due_points.pop_front();
					if (got.kind !== want.kind)
						log_fault($sformatf("slot %0d point %0d: entry_kind %0b, expected %0b",
							want.slot, want.point, got.kind, want.kind));
					if (got.slot !== want.slot)
						log_fault($sformatf("slot %0d point %0d: slot_index %0d",
							want.slot, want.point, got.slot));
					if (got.point !== want.point)
						log_fault($sformatf("slot %0d point %0d: point_number %0d",
							want.slot, want.point, got.point));
					if (got.x !== want.x)
						log_fault($sformatf("slot %0d point %0d: x_value %0d, expected %0d",
							want.slot, want.point, $signed(got.x), $signed(want.x)));
					if (got.y !== want.y)
						log_fault($sformatf("slot %0d point %0d: y_value %0d, expected %0d",
							want.slot, want.point, $signed(got.y), $signed(want.y)));
					if (got.last !== want.last)
						log_fault($sformatf("slot %0d point %0d: last %0b, expected %0b",
							want.slot, want.point, got.last, want.last));
				end
			end
			if (item.valid && item.ready)
				predict_curve(item.curve_type, item.frame_index,
					item.ctrl_x1, item.ctrl_y1, item.ctrl_x2, item.ctrl_y2);
			waiting <= due_points.size();
			faults  <= fault_total;
		end
	end

endmodule

// File: verif/tb_top.sv
// Testbench top of the Bezier curve sampler: clock, reset, stimulus, flow control and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bcs_pkg::*;

	// Random items sent after the directed set, of every type code.
	localparam int RANDOM_ITEMS   = 408;
	// Cycles without any transaction before the run is declared hung. The longest
	// correct quiet stretch is the deliberate result hold-off below.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last expected result, well above the pipeline latency.
	localparam int DRAIN_CYCLES   = 20;
	// Long result hold-off that fills the pipeline and stalls the input side.
	localparam int HOLD_CYCLES    = 150;
	localparam int HOLD_START     = 400;
	localparam int Q16_ONE        = 65536;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} curve_req_t;

	logic clk;
	logic arst_n;
	logic holding;
	int   fault_count;
	int   pending_points;
	int   burst_left = 0;

	bcs_in_if  item_ch ();
	bcs_out_if result_ch ();

	bezier_curve_sampler_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch.sink),
		.result (result_ch.source)
	);

	// The scoreboard watches both channels; this module only drives them.
	bcs_scoreboard u_scoreboard (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.faults  (fault_count),
		.waiting (pending_points)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Builds a request from plain integers; coordinates are Q4.16 in two's complement.
	function automatic curve_req_t make_req(input logic [KIND_W-1:0] kind, input int slot,
			input int x1, input int y1, input int x2, input int y2);
		curve_req_t r;
		r.kind = kind;
		r.slot = SLOT_W'(slot);
		r.x1   = COORD_W'(x1);
		r.y1   = COORD_W'(y1);
		r.x2   = COORD_W'(x2);
		r.y2   = COORD_W'(y2);
		return r;
	endfunction

	// Random control value. Half the draws stay near the usual curve range of a few units,
	// so the sampled points land inside the output range; the rest use the whole
	// 20-bit field or its extremes, which drives the saturation logic.
	function automatic logic [COORD_W-1:0] rand_coord();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
		if (pick == 4)
			return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
		return COORD_W'($urandom_range(0, 5 * Q16_ONE) - 2 * Q16_ONE);
	endfunction

	// Offers one request and returns at the edge where its transaction happens.
	// The sender works in bursts: once a burst is used up it may drop valid for a
	// random gap, which moves the next transaction to a new phase of the stepper.
	// While the result side is held off the gaps are skipped, so the input keeps
	// offering and the block must push back with ready.
	task automatic send(input curve_req_t req);
		int gap;
		item_ch.valid       <= 1'b1;
		item_ch.curve_type  <= req.kind;
		item_ch.frame_index <= req.slot;
		item_ch.ctrl_x1     <= req.x1;
		item_ch.ctrl_y1     <= req.y1;
		item_ch.ctrl_x2     <= req.x2;
		item_ch.ctrl_y2     <= req.y2;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			if (holding || $urandom_range(0, 3) == 0)
				gap = 0;
			else
				gap = $urandom_range(1, 15);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stimulus: reset, a directed set of corner items, then random items.
	initial begin : stimulus
		curve_req_t req;
		int         counted;
		int         pick;
		item_ch.valid       = 1'b0;
		item_ch.curve_type  = '0;
		item_ch.frame_index = '0;
		item_ch.ctrl_x1     = '0;
		item_ch.ctrl_y1     = '0;
		item_ch.ctrl_x2     = '0;
		item_ch.ctrl_y2     = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stepped markers at both slot extremes; their control values must not leak out.
		send(make_req(TYPE_STEPPED, 0, 0, 0, 0, 0));
		send(make_req(TYPE_STEPPED, 1023, -524288, 524287, 524287, -524288));
		// Bezier curves: all zero, a common ease curve, the field extremes and one unit-corner curve.
		send(make_req(TYPE_BEZIER, 1, 0, 0, 0, 0));
		send(make_req(TYPE_BEZIER, 2, 16384, 6554, 16384, Q16_ONE));
		send(make_req(TYPE_BEZIER, 3, 524287, 524287, 524287, 524287));
		send(make_req(TYPE_BEZIER, 4, -524288, -524288, -524288, -524288));
		send(make_req(TYPE_BEZIER, 5, -524288, 524287, 524287, -524288));
		send(make_req(TYPE_BEZIER, 6, 524287, -524288, -524288, 524287));
		send(make_req(TYPE_BEZIER, 7, Q16_ONE, 0, Q16_ONE, Q16_ONE));
		// Linear and unknown types produce nothing, including a high-bit code.
		send(make_req(8'd0, 8, Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE));
		send(make_req(8'd3, 9, 1, 2, 3, 4));
		send(make_req(8'd255, 10, -1, -1, -1, -1));
		send(make_req(8'd128, 11, 0, 0, 0, 0));
		// Alternating slot bit patterns and all-ones control words.
		send(make_req(TYPE_BEZIER, 682, -1, -1, -1, -1));
		send(make_req(TYPE_STEPPED, 341, 0, 0, 0, 0));
		send(make_req(TYPE_BEZIER, 1023, 32768, -32768, 98304, 163840));
		// Back-to-back stepped items, then a curve right behind a marker.
		send(make_req(TYPE_STEPPED, 12, 0, 0, 0, 0));
		send(make_req(TYPE_STEPPED, 13, 0, 0, 0, 0));
		send(make_req(TYPE_STEPPED, 14, 0, 0, 0, 0));
		send(make_req(TYPE_BEZIER, 15, 27525, 0, 45875, Q16_ONE));
		send(make_req(8'd0, 16, 0, 0, 0, 0));
		send(make_req(TYPE_BEZIER, 17, 0, Q16_ONE, Q16_ONE, 0));

		// Random part: mostly curves, some markers and a share of other type codes.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				req.kind = TYPE_BEZIER;
			else if (pick < 85)
				req.kind = TYPE_STEPPED;
			else
				req.kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
			req.slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
			req.x1   = rand_coord();
			req.y1   = rand_coord();
			req.x2   = rand_coord();
			req.y2   = rand_coord();
			counted++;
			send(req);
		end
		item_ch.valid <= 1'b0;

		// The scoreboard count is registered, so the bench waits for the next edge before reading it.
		@(posedge clk);
		while (pending_points != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Result side flow control. Stretches of random length each follow one pattern:
	// always ready, coin flip, mostly ready or mostly stalled. Once the summed spans reach
	// HOLD_START, ready stays low for a long hold-off.
	initial begin : receiver
		int  style;
		int  span;
		int  elapsed;
		bit  hold_done;
		result_ch.ready = 1'b0;
		holding         = 1'b0;
		elapsed         = 0;
		hold_done       = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && elapsed >= HOLD_START) begin
				holding         <= 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding   <= 1'b0;
				hold_done = 1'b1;
			end
			style = $urandom_range(0, 3);
			span  = $urandom_range(5, 40);
			for (int i = 0; i < span; i++) begin
				case (style)
					0: begin
						result_ch.ready <= 1'b1;
					end
					1: begin
						result_ch.ready <= ($urandom_range(0, 1) != 0);
					end
					2: begin
						result_ch.ready <= ($urandom_range(0, 7) != 0);
					end
					default: begin
						result_ch.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
				@(posedge clk);
			end
			elapsed += span;
		end
	end

	// Hang detection: any transaction on either channel restarts the count.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// File: bezier_curve_sampler_core.f
src/bcs_pkg.sv
src/bcs_in_if.sv
src/bcs_out_if.sv
src/bcs_axis_setup.sv
src/bcs_stepper.sv
src/bezier_curve_sampler_core.sv
src/bcs_checker.sv
verif/bcs_checker.sv
verif/tb_top.sv
